FILE: sv/lpsp_pkg.sv
// ----------------------------------------------------------------------------
// lpsp_pkg
// Shared types, constants and the arctangent table of the lidar point
// spherical projection pipeline.
// ----------------------------------------------------------------------------
package lpsp_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int MAX_ROWS         = 128;
	localparam int MAX_COLUMNS      = 2048;
	localparam int SQRT_STEPS       = 32;

	localparam logic [32:0] PI_Q30      = 33'd3373259426;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
	localparam logic [63:0] HALF_Q44    = 64'h0000_0800_0000_0000;
	localparam logic [39:0] DEPTH_LIMIT = 40'hFF_FF00_0000;

	// register indexes
	localparam logic [2:0] REG_START_ELEVATION  = 3'd0;
	localparam logic [2:0] REG_ELEVATION_STEP   = 3'd1;
	localparam logic [2:0] REG_AZIMUTH_STEP     = 3'd2;
	localparam logic [2:0] REG_ROW_COUNT        = 3'd3;
	localparam logic [2:0] REG_COLUMN_COUNT     = 3'd4;
	localparam logic [2:0] REG_VALUE_SCALE      = 3'd5;
	localparam logic [2:0] REG_HEIGHT_OFFSET    = 3'd6;

	// register reset values
	localparam logic [30:0] RST_START_ELEVATION = 31'd0;
	localparam logic [31:0] RST_ELEVATION_STEP  = 32'd10597769;
	localparam logic [31:0] RST_AZIMUTH_STEP    = 32'd21350645;
	localparam logic [7:0]  RST_ROW_COUNT       = 8'd128;
	localparam logic [11:0] RST_COLUMN_COUNT    = 12'd2048;
	localparam logic [23:0] RST_VALUE_SCALE     = 24'd256000;
	localparam logic [31:0] RST_HEIGHT_OFFSET   = 32'd655360;

	typedef struct packed {
		logic signed [31:0] x_position;
		logic signed [31:0] y_position;
		logic signed [31:0] z_position;
		logic [15:0]        point_label;
	} in_item_t;

	typedef struct packed {
		logic        pixel_valid;
		logic [6:0]  pixel_row;
		logic [10:0] pixel_column;
		logic [15:0] depth_value;
		logic        depth_valid;
		logic [15:0] height_value;
		logic        height_valid;
		logic [15:0] label_value;
	} out_item_t;

	typedef struct packed {
		logic [30:0]        start_elevation;
		logic [31:0]        elevation_step_inverse;
		logic [31:0]        azimuth_step_inverse;
		logic [7:0]         row_count;
		logic [11:0]        column_count;
		logic [23:0]        value_scale;
		logic signed [31:0] height_offset;
	} cfg_t;

	typedef struct packed {
		logic               x_neg;
		logic               y_neg;
		logic               z_neg;
		logic [31:0]        ax;
		logic [31:0]        ay;
		logic [31:0]        az;
		logic signed [31:0] z_position;
		logic [15:0]        point_label;
	} side_t;

	typedef struct packed {
		logic [63:0] sr;
		logic [63:0] sxy;
		side_t       side;
	} rad_t;

	typedef struct packed {
		logic [31:0] r;
		logic [31:0] rho;
		side_t       side;
	} root_t;

	typedef struct packed {
		logic [30:0] elev_a0;
		logic [30:0] azim_a0;
		logic [31:0] r;
		side_t       side;
	} ang_t;

	function automatic logic [30:0] atan_q30(input int i);
		logic [30:0] v;
		case (i)
			0:  v = 31'h3243F6A8;
			1:  v = 31'h1DAC6705;
			2:  v = 31'h0FADBAFC;
			3:  v = 31'h07F56EA6;
			4:  v = 31'h03FEAB76;
			5:  v = 31'h01FFD55B;
			6:  v = 31'h00FFFAAA;
			7:  v = 31'h007FFF55;
			8:  v = 31'h003FFFEA;
			9:  v = 31'h001FFFFD;
			10: v = 31'h000FFFFF;
			11: v = 31'h0007FFFF;
			12: v = 31'h0003FFFF;
			13: v = 31'h0001FFFF;
			14: v = 31'h0000FFFF;
			15: v = 31'h00007FFF;
			16: v = 31'h00003FFF;
			17: v = 31'h00001FFF;
			18: v = 31'h00000FFF;
			19: v = 31'h000007FF;
			20: v = 31'h000003FF;
			21: v = 31'h000001FF;
			22: v = 31'h000000FF;
			23: v = 31'h0000007F;
			24: v = 31'h0000003F;
			25: v = 31'h0000001F;
			26: v = 31'h0000000F;
			27: v = 31'h00000008;
			28: v = 31'h00000004;
			29: v = 31'h00000002;
			30: v = 31'h00000001;
			default: v = 31'h00000000;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/lpsp_front.sv
// ----------------------------------------------------------------------------
// lpsp_front
// Absolute values, squares and the two radicands, three register stages.
// ----------------------------------------------------------------------------
module lpsp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lpsp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lpsp_pkg::rad_t      out_data
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	lpsp_pkg::side_t side_s1, side_s2, side_s3, side_in;
	logic [63:0] sx_s2, sy_s2, sz_s2;
	logic [63:0] sr_s3, sxy_s3;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		side_in.x_neg       = in_data.x_position[31];
		side_in.y_neg       = in_data.y_position[31];
		side_in.z_neg       = in_data.z_position[31];
		side_in.ax          = in_data.x_position[31] ? (~in_data.x_position + 32'd1)
			: in_data.x_position;
		side_in.ay          = in_data.y_position[31] ? (~in_data.y_position + 32'd1)
			: in_data.y_position;
		side_in.az          = in_data.z_position[31] ? (~in_data.z_position + 32'd1)
			: in_data.z_position;
		side_in.z_position  = in_data.z_position;
		side_in.point_label = in_data.point_label;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			side_s1 <= side_in;
		end
		if (v_s1 && rdy2) begin
			sx_s2   <= {32'd0, side_s1.ax} * {32'd0, side_s1.ax};
			sy_s2   <= {32'd0, side_s1.ay} * {32'd0, side_s1.ay};
			sz_s2   <= {32'd0, side_s1.az} * {32'd0, side_s1.az};
			side_s2 <= side_s1;
		end
		if (v_s2 && rdy3) begin
			// sum of three squares stays below 2^64
			sr_s3   <= sx_s2 + sy_s2 + sz_s2;
			sxy_s3  <= sx_s2 + sy_s2;
			side_s3 <= side_s2;
		end
	end

	assign out_valid     = v_s3;
	assign out_data.sr   = sr_s3;
	assign out_data.sxy  = sxy_s3;
	assign out_data.side = side_s3;

endmodule

FILE: sv/lpsp_sqrt.sv
// ----------------------------------------------------------------------------
// lpsp_sqrt
// Two 64-bit integer square roots side by side, one result bit per stage.
// ----------------------------------------------------------------------------
module lpsp_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lpsp_pkg::rad_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output lpsp_pkg::root_t  out_data
);

	localparam int N = lpsp_pkg::SQRT_STEPS;

	typedef struct packed {
		logic [63:0] n;
		logic [63:0] res;
	} sq_t;

	function automatic sq_t sqrt_step(input sq_t a, input logic [63:0] b);
		sq_t o;
		logic [64:0] t;
		t = {1'b0, a.res} + {1'b0, b};
		if ({1'b0, a.n} >= t) begin
			o.n   = a.n - t[63:0];
			o.res = (a.res >> 1) + b;
		end else begin
			o.n   = a.n;
			o.res = a.res >> 1;
		end
		return o;
	endfunction

	logic            vld_s   [N];
	logic            rdy     [N];
	sq_t             range_s [N];
	sq_t             rho_s   [N];
	lpsp_pkg::side_t side_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic            prev_v;
		sq_t             prev_r, prev_p;
		lpsp_pkg::side_t prev_side;
		logic [63:0]     b;

		assign b = 64'd1 << (2 * (N - 1 - k));

		if (k == 0) begin : g_first
			assign prev_v    = in_valid;
			assign prev_r    = '{n: in_data.sr, res: 64'd0};
			assign prev_p    = '{n: in_data.sxy, res: 64'd0};
			assign prev_side = in_data.side;
		end else begin : g_next
			assign prev_v    = vld_s[k-1];
			assign prev_r    = range_s[k-1];
			assign prev_p    = rho_s[k-1];
			assign prev_side = side_s[k-1];
		end

		if (k == N - 1) begin : g_last
			assign rdy[k] = !vld_s[k] || out_ready;
		end else begin : g_mid
			assign rdy[k] = !vld_s[k] || rdy[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (prev_v && rdy[k]) begin
				range_s[k] <= sqrt_step(prev_r, b);
				rho_s[k]   <= sqrt_step(prev_p, b);
				side_s[k]  <= prev_side;
			end
		end
	end

	assign in_ready      = rdy[0];
	assign out_valid     = vld_s[N-1];
	assign out_data.r    = range_s[N-1].res[31:0];
	assign out_data.rho  = rho_s[N-1].res[31:0];
	assign out_data.side = side_s[N-1];

endmodule

FILE: sv/lpsp_cordic.sv
// ----------------------------------------------------------------------------
// lpsp_cordic
// Two vectoring CORDIC pipelines (elevation and azimuth): two normalize
// stages, then one rotation per stage.
// ----------------------------------------------------------------------------
module lpsp_cordic #(
	parameter int CORDIC_STEPS = lpsp_pkg::CORDIC_STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lpsp_pkg::root_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output lpsp_pkg::ang_t   out_data
);

	localparam int NS = CORDIC_STEPS + 2;

	typedef struct packed {
		logic [38:0] a;
		logic [38:0] b;
	} pair_t;

	typedef struct packed {
		logic signed [42:0] x;
		logic signed [42:0] y;
		logic signed [33:0] ang;
	} cv_t;

	function automatic pair_t norm_shift(input pair_t p, input int s);
		pair_t o;
		logic [38:0] m;
		m = p.a | p.b;
		o = p;
		if ((m >> (39 - s)) == 39'd0) begin
			o.a = p.a << s;
			o.b = p.b << s;
		end
		return o;
	endfunction

	function automatic cv_t cordic_step(input cv_t c, input int i);
		cv_t o;
		logic signed [42:0] cx, cy, xs, ys;
		logic signed [33:0] at;
		cx = c.x;
		cy = c.y;
		xs = cx >>> i;
		ys = cy >>> i;
		at = $signed({3'b000, lpsp_pkg::atan_q30(i)});
		if (!cy[42]) begin
			o.x   = cx + ys;
			o.y   = cy - xs;
			o.ang = c.ang + at;
		end else begin
			o.x   = cx - ys;
			o.y   = cy + xs;
			o.ang = c.ang - at;
		end
		return o;
	endfunction

	function automatic logic [30:0] clamp_ang(input logic signed [33:0] a, input logic zero);
		logic [30:0] v;
		if (zero || a[33]) begin
			v = 31'd0;
		end else if (a > $signed({3'b000, lpsp_pkg::HALF_PI_Q30})) begin
			v = lpsp_pkg::HALF_PI_Q30;
		end else begin
			v = a[30:0];
		end
		return v;
	endfunction

	logic            vld_s  [NS];
	logic            rdy    [NS];
	lpsp_pkg::side_t side_s [NS];
	logic [31:0]     r_s    [NS];
	logic            ez_s   [NS];
	logic            az_s   [NS];
	pair_t           pe_s   [2];
	pair_t           pa_s   [2];
	cv_t             ce_s   [CORDIC_STEPS];
	cv_t             ca_s   [CORDIC_STEPS];

	pair_t pe_in, pa_in, pe_n1, pa_n1, pe_n2, pa_n2;

	for (genvar k = 0; k < NS; k++) begin : g_rdy
		if (k == NS - 1) begin : g_last
			assign rdy[k] = !vld_s[k] || out_ready;
		end else begin : g_mid
			assign rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	// normalize so the larger component has its top bit at bit 38
	always_comb begin
		pe_in = '{a: {7'd0, in_data.side.az}, b: {7'd0, in_data.rho}};
		pa_in = '{a: {7'd0, in_data.side.ax}, b: {7'd0, in_data.side.ay}};
		pe_n1 = norm_shift(norm_shift(norm_shift(pe_in, 32), 16), 8);
		pa_n1 = norm_shift(norm_shift(norm_shift(pa_in, 32), 16), 8);
		pe_n2 = norm_shift(norm_shift(norm_shift(pe_s[0], 4), 2), 1);
		pa_n2 = norm_shift(norm_shift(norm_shift(pa_s[0], 4), 2), 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
			vld_s[1] <= 1'b0;
		end else begin
			if (rdy[0]) vld_s[0] <= in_valid;
			if (rdy[1]) vld_s[1] <= vld_s[0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy[0]) begin
			pe_s[0]   <= pe_n1;
			pa_s[0]   <= pa_n1;
			side_s[0] <= in_data.side;
			r_s[0]    <= in_data.r;
			ez_s[0]   <= (in_data.side.az == 32'd0) && (in_data.rho == 32'd0);
			az_s[0]   <= (in_data.side.ax == 32'd0) && (in_data.side.ay == 32'd0);
		end
		if (vld_s[0] && rdy[1]) begin
			pe_s[1]   <= pe_n2;
			pa_s[1]   <= pa_n2;
			side_s[1] <= side_s[0];
			r_s[1]    <= r_s[0];
			ez_s[1]   <= ez_s[0];
			az_s[1]   <= az_s[0];
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		cv_t prev_e, prev_a;

		if (i == 0) begin : g_first
			assign prev_e = '{x: $signed({4'd0, pe_s[1].a}), y: $signed({4'd0, pe_s[1].b}),
				ang: 34'sd0};
			assign prev_a = '{x: $signed({4'd0, pa_s[1].a}), y: $signed({4'd0, pa_s[1].b}),
				ang: 34'sd0};
		end else begin : g_next
			assign prev_e = ce_s[i-1];
			assign prev_a = ca_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+2] <= 1'b0;
			end else if (rdy[i+2]) begin
				vld_s[i+2] <= vld_s[i+1];
			end
		end

		always_ff @(posedge clk) begin
			if (vld_s[i+1] && rdy[i+2]) begin
				ce_s[i]     <= cordic_step(prev_e, i);
				ca_s[i]     <= cordic_step(prev_a, i);
				side_s[i+2] <= side_s[i+1];
				r_s[i+2]    <= r_s[i+1];
				ez_s[i+2]   <= ez_s[i+1];
				az_s[i+2]   <= az_s[i+1];
			end
		end
	end

	assign in_ready         = rdy[0];
	assign out_valid        = vld_s[NS-1];
	assign out_data.elev_a0 = clamp_ang(ce_s[CORDIC_STEPS-1].ang, ez_s[NS-1]);
	assign out_data.azim_a0 = clamp_ang(ca_s[CORDIC_STEPS-1].ang, az_s[NS-1]);
	assign out_data.r       = r_s[NS-1];
	assign out_data.side    = side_s[NS-1];

endmodule

FILE: sv/lpsp_back.sv
// ----------------------------------------------------------------------------
// lpsp_back
// Angle folding, row and column scaling with rounding, column wrap and the
// depth and height values, five register stages ending in the output register.
// ----------------------------------------------------------------------------
module lpsp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lpsp_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  lpsp_pkg::ang_t      in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lpsp_pkg::out_item_t out_data
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// stage 1
	logic [30:0]        elev28_s1, azim28_s1;
	logic signed [32:0] hsum_s1;
	logic [31:0]        r_s1;
	logic [15:0]        label_s1;
	// stage 2
	logic [30:0]        mag_s2, azim28_s2;
	logic               neg_s2, rnz_s2;
	logic [55:0]        dprod_s2;
	logic signed [57:0] hprod_s2;
	logic [15:0]        label_s2;
	// stage 3
	logic [62:0]        eprod_s3, aprod_s3;
	logic               neg_s3, rnz_s3;
	logic [15:0]        dval_s3, hval_s3, label_s3;
	logic               dok_s3, hok_s3;
	// stage 4
	logic [19:0]        q_s4, col_s4;
	logic               neg_s4, rnz_s4;
	logic [15:0]        dval_s4, hval_s4, label_s4;
	logic               dok_s4, hok_s4;
	// stage 5
	lpsp_pkg::out_item_t res_s5;

	logic [32:0]        elev30, azim30, elev_rnd, azim_rnd;
	logic signed [31:0] diff;
	logic [63:0]        erow, acol;
	logic [19:0]        rows, cols, col_w;
	logic               pix_ok;

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		elev30 = in_data.side.z_neg ? (lpsp_pkg::PI_Q30 - {2'b00, in_data.elev_a0})
			: {2'b00, in_data.elev_a0};
		case ({in_data.side.x_neg, in_data.side.y_neg})
			2'b00:   azim30 = lpsp_pkg::PI_Q30 - {2'b00, in_data.azim_a0};
			2'b10:   azim30 = {2'b00, in_data.azim_a0};
			2'b01:   azim30 = lpsp_pkg::PI_Q30 + {2'b00, in_data.azim_a0};
			default: azim30 = lpsp_pkg::TWO_PI_Q30 - {2'b00, in_data.azim_a0};
		endcase
		elev_rnd = elev30 + 33'd2;
		azim_rnd = azim30 + 33'd2;

		diff = $signed({1'b0, elev28_s1}) - $signed({1'b0, cfg.start_elevation});

		erow = {1'b0, eprod_s3} + lpsp_pkg::HALF_Q44;
		acol = {1'b0, aprod_s3} + lpsp_pkg::HALF_Q44;

		rows = (20'(cfg.row_count) < 20'(lpsp_pkg::MAX_ROWS)) ? 20'(cfg.row_count)
			: 20'(lpsp_pkg::MAX_ROWS);
		cols = (20'(cfg.column_count) < 20'(lpsp_pkg::MAX_COLUMNS)) ? 20'(cfg.column_count)
			: 20'(lpsp_pkg::MAX_COLUMNS);
		// a small negative ratio that rounds to zero still lands on row zero
		pix_ok = rnz_s4 && !(neg_s4 && q_s4 != 20'd0) && (q_s4 < rows);
		col_w  = (col_s4 >= cols) ? (col_s4 - cols) : col_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			elev28_s1 <= elev_rnd[32:2];
			azim28_s1 <= azim_rnd[32:2];
			hsum_s1   <= {in_data.side.z_position[31], in_data.side.z_position}
				+ {cfg.height_offset[31], cfg.height_offset};
			r_s1      <= in_data.r;
			label_s1  <= in_data.side.point_label;
		end
		if (v_s1 && rdy2) begin
			neg_s2    <= diff[31];
			mag_s2    <= diff[31] ? 31'(-diff) : diff[30:0];
			azim28_s2 <= azim28_s1;
			rnz_s2    <= (r_s1 != 32'd0);
			dprod_s2  <= {24'd0, r_s1} * {32'd0, cfg.value_scale};
			hprod_s2  <= $signed({{25{hsum_s1[32]}}, hsum_s1})
				* $signed({34'd0, cfg.value_scale});
			label_s2  <= label_s1;
		end
		if (v_s2 && rdy3) begin
			eprod_s3 <= {32'd0, mag_s2} * {31'd0, cfg.elevation_step_inverse};
			aprod_s3 <= {32'd0, azim28_s2} * {31'd0, cfg.azimuth_step_inverse};
			neg_s3   <= neg_s2;
			rnz_s3   <= rnz_s2;
			dok_s3   <= dprod_s2 <= 56'(lpsp_pkg::DEPTH_LIMIT);
			dval_s3  <= dprod_s2[39:24];
			hok_s3   <= !hprod_s2[57] && (hprod_s2[56:0] <= 57'(lpsp_pkg::DEPTH_LIMIT));
			hval_s3  <= hprod_s2[39:24];
			label_s3 <= label_s2;
		end
		if (v_s3 && rdy4) begin
			q_s4     <= erow[63:44];
			col_s4   <= acol[63:44];
			neg_s4   <= neg_s3;
			rnz_s4   <= rnz_s3;
			dok_s4   <= dok_s3;
			dval_s4  <= dok_s3 ? dval_s3 : 16'd0;
			hok_s4   <= hok_s3;
			hval_s4  <= hok_s3 ? hval_s3 : 16'd0;
			label_s4 <= label_s3;
		end
		if (v_s4 && rdy5) begin
			res_s5.pixel_valid  <= pix_ok;
			res_s5.pixel_row    <= pix_ok ? q_s4[6:0] : 7'd0;
			res_s5.pixel_column <= pix_ok ? col_w[10:0] : 11'd0;
			res_s5.depth_value  <= dval_s4;
			res_s5.depth_valid  <= dok_s4;
			res_s5.height_value <= hval_s4;
			res_s5.height_valid <= hok_s4;
			res_s5.label_value  <= label_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = res_s5;

endmodule

FILE: sv/lidar_point_spherical_projection.sv
// ----------------------------------------------------------------------------
// lidar_point_spherical_projection
// Maps one lidar point per cycle, when not held by backpressure, to a
// range-image pixel with depth, height and label values.
// ----------------------------------------------------------------------------
// The block takes one point per clock while no stage is stalled and gives one
// result per point, in order, through the squaring stages, the square root at
// one root bit per stage, two normalize stages, one stage per CORDIC rotation,
// and five stages of scaling and rounding of which the last is the output
// register. Every stage holds its item under backpressure and passes it on as
// soon as the next stage frees up, so bubbles close up and the input keeps
// taking points while a result waits at the output, until every stage is full.
// Configuration registers are written through their own port, which is always
// ready.
module lidar_point_spherical_projection #(
	parameter int CORDIC_STEPS = lpsp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lpsp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lpsp_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	lpsp_pkg::cfg_t  cfg_q;
	lpsp_pkg::rad_t  rad;
	lpsp_pkg::root_t root;
	lpsp_pkg::ang_t  ang;
	logic rad_valid, rad_ready, root_valid, root_ready, ang_valid, ang_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_elevation        <= lpsp_pkg::RST_START_ELEVATION;
			cfg_q.elevation_step_inverse <= lpsp_pkg::RST_ELEVATION_STEP;
			cfg_q.azimuth_step_inverse   <= lpsp_pkg::RST_AZIMUTH_STEP;
			cfg_q.row_count              <= lpsp_pkg::RST_ROW_COUNT;
			cfg_q.column_count           <= lpsp_pkg::RST_COLUMN_COUNT;
			cfg_q.value_scale            <= lpsp_pkg::RST_VALUE_SCALE;
			cfg_q.height_offset          <= $signed(lpsp_pkg::RST_HEIGHT_OFFSET);
		end else if (cfg_valid) begin
			case (cfg_index)
				lpsp_pkg::REG_START_ELEVATION: cfg_q.start_elevation <= cfg_data[30:0];
				lpsp_pkg::REG_ELEVATION_STEP:  cfg_q.elevation_step_inverse <= cfg_data;
				lpsp_pkg::REG_AZIMUTH_STEP:    cfg_q.azimuth_step_inverse <= cfg_data;
				lpsp_pkg::REG_ROW_COUNT:       cfg_q.row_count <= cfg_data[7:0];
				lpsp_pkg::REG_COLUMN_COUNT:    cfg_q.column_count <= cfg_data[11:0];
				lpsp_pkg::REG_VALUE_SCALE:     cfg_q.value_scale <= cfg_data[23:0];
				lpsp_pkg::REG_HEIGHT_OFFSET:   cfg_q.height_offset <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	lpsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (rad_valid),
		.out_ready (rad_ready),
		.out_data  (rad)
	);

	lpsp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rad_valid),
		.in_ready  (rad_ready),
		.in_data   (rad),
		.out_valid (root_valid),
		.out_ready (root_ready),
		.out_data  (root)
	);

	lpsp_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_valid),
		.in_ready  (root_ready),
		.in_data   (root),
		.out_valid (ang_valid),
		.out_ready (ang_ready),
		.out_data  (ang)
	);

	lpsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (ang_valid),
		.in_ready  (ang_ready),
		.in_data   (ang),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: sv/lpsp_checker.sv
// ----------------------------------------------------------------------------
// lpsp_checker
// Port-level checks of the projection block, bound to the top level.
// ----------------------------------------------------------------------------
module lpsp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input lpsp_pkg::out_item_t out_data,
	input logic                cfg_valid,
	input logic                cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// an invalid pixel reports row and column zero
	a_pix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.pixel_valid |->
			out_data.pixel_row == 7'd0 && out_data.pixel_column == 11'd0)
		else $error("invalid pixel with nonzero address");

	// overflowed values are cleared
	a_val_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(out_data.depth_valid || out_data.depth_value == 16'd0) &&
			(out_data.height_valid || out_data.height_value == 16'd0))
		else $error("invalid depth or height with nonzero value");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind lidar_point_spherical_projection lpsp_checker u_lpsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams lidar points through the spherical projection pipeline under random
// idling and backpressure and checks every pixel against a local predictor.
// ----------------------------------------------------------------------------
module testbench;

	localparam int PIPE_LATENCY = lpsp_pkg::CORDIC_STEPS_DEF + 42;
	localparam logic [63:0] VALUE_LIMIT = 64'd65535 << 24;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	lpsp_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	lpsp_pkg::out_item_t out_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [2:0]          cfg_index = '0;
	logic [31:0]         cfg_data = '0;

	int  cycle_count = 0;
	int  error_count = 0;
	bit  long_stall = 1'b0;

	always #6 clk = ~clk;

	lidar_point_spherical_projection dut (.*);

	// projection settings mirrored from the register writes
	lpsp_pkg::cfg_t proj_cfg;

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// vectoring rotation, angle of (a,b) in Q2.30 within [0, pi/2]
	function automatic longint cordic_angle(input logic [63:0] a, input logic [63:0] b);
		longint x, y, nx, ny, ang;
		ang = 0;
		if (a == 0 && b == 0) return 0;
		while ((a | b) < (64'd1 << 38)) begin
			a <<= 1;
			b <<= 1;
		end
		x = a;
		y = b;
		for (int i = 0; i < lpsp_pkg::CORDIC_STEPS_DEF; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				ang += longint'(lpsp_pkg::atan_q30(i));
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				ang -= longint'(lpsp_pkg::atan_q30(i));
			end
			x = nx;
			y = ny;
		end
		if (ang < 0) ang = 0;
		if (ang > longint'(lpsp_pkg::HALF_PI_Q30)) ang = longint'(lpsp_pkg::HALF_PI_Q30);
		return ang;
	endfunction

	function automatic lpsp_pkg::out_item_t project_point(input lpsp_pkg::in_item_t p);
		lpsp_pkg::out_item_t o;
		longint x, y, z, a0, elev, azim, diff, hprod;
		logic [63:0] ax, ay, az, sxy, r, rho, mag, q, col, rows, cols, dprod;
		bit valid, neg;
		x = p.x_position;
		y = p.y_position;
		z = p.z_position;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		az = z < 0 ? -z : z;
		sxy = ax * ax + ay * ay;
		r = int_sqrt(sxy + az * az);
		rho = int_sqrt(sxy);
		valid = r != 0;
		a0 = cordic_angle(az, rho);
		elev = z >= 0 ? a0 : longint'(lpsp_pkg::PI_Q30) - a0;
		elev = (elev + 2) >>> 2;
		a0 = cordic_angle(ax, ay);
		if (x >= 0 && y >= 0) azim = longint'(lpsp_pkg::PI_Q30) - a0;
		else if (x < 0 && y >= 0) azim = a0;
		else if (x >= 0) azim = longint'(lpsp_pkg::PI_Q30) + a0;
		else azim = longint'(lpsp_pkg::TWO_PI_Q30) - a0;
		azim = (azim + 2) >>> 2;
		diff = elev - longint'(proj_cfg.start_elevation);
		neg = diff < 0;
		mag = 64'(neg ? -diff : diff) * 64'(proj_cfg.elevation_step_inverse);
		q = (mag + lpsp_pkg::HALF_Q44) >> 44;
		rows = 64'(proj_cfg.row_count < lpsp_pkg::MAX_ROWS ? proj_cfg.row_count
			: lpsp_pkg::MAX_ROWS);
		if ((neg && q != 0) || q >= rows) valid = 0;
		col = (64'(azim) * 64'(proj_cfg.azimuth_step_inverse) + lpsp_pkg::HALF_Q44) >> 44;
		cols = 64'(proj_cfg.column_count < lpsp_pkg::MAX_COLUMNS ? proj_cfg.column_count
			: lpsp_pkg::MAX_COLUMNS);
		if (col >= cols) col -= cols;
		o = '0;
		o.pixel_valid = valid;
		o.pixel_row = valid ? q[6:0] : '0;
		o.pixel_column = valid ? col[10:0] : '0;
		dprod = r * 64'(proj_cfg.value_scale);
		if (dprod <= VALUE_LIMIT) begin
			o.depth_value = dprod[39:24];
			o.depth_valid = 1'b1;
		end
		hprod = (z + longint'(proj_cfg.height_offset)) * longint'(proj_cfg.value_scale);
		if (hprod >= 0 && 64'(hprod) <= VALUE_LIMIT) begin
			o.height_value = hprod[39:24];
			o.height_valid = 1'b1;
		end
		o.label_value = p.point_label;
		return o;
	endfunction

	class pixel_scoreboard;
		lpsp_pkg::out_item_t pending_pixels[$];

		function void note_point(lpsp_pkg::in_item_t p);
			pending_pixels = {pending_pixels, project_point(p)};
		endfunction

		function void check_pixel(lpsp_pkg::out_item_t got);
			lpsp_pkg::out_item_t e;
			if (pending_pixels.size() == 0) begin
				$error("pixel with no point outstanding: %h", got);
				error_count++;
				return;
			end
			e = pending_pixels.pop_front();
			if (got.pixel_valid !== e.pixel_valid) begin
				$error("pixel_valid exp %0d got %0d", e.pixel_valid, got.pixel_valid);
				error_count++;
			end
			if (got.pixel_row !== e.pixel_row) begin
				$error("pixel_row exp %0d got %0d", e.pixel_row, got.pixel_row);
				error_count++;
			end
			if (got.pixel_column !== e.pixel_column) begin
				$error("pixel_column exp %0d got %0d", e.pixel_column, got.pixel_column);
				error_count++;
			end
			if (got.depth_value !== e.depth_value) begin
				$error("depth_value exp %0d got %0d", e.depth_value, got.depth_value);
				error_count++;
			end
			if (got.depth_valid !== e.depth_valid) begin
				$error("depth_valid exp %0d got %0d", e.depth_valid, got.depth_valid);
				error_count++;
			end
			if (got.height_value !== e.height_value) begin
				$error("height_value exp %0d got %0d", e.height_value, got.height_value);
				error_count++;
			end
			if (got.height_valid !== e.height_valid) begin
				$error("height_valid exp %0d got %0d", e.height_valid, got.height_valid);
				error_count++;
			end
			if (got.label_value !== e.label_value) begin
				$error("label_value exp %0d got %0d", e.label_value, got.label_value);
				error_count++;
			end
		endfunction
	endclass

	pixel_scoreboard board = new();

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lpsp_pkg::REG_START_ELEVATION: proj_cfg.start_elevation = val[30:0];
			lpsp_pkg::REG_ELEVATION_STEP:  proj_cfg.elevation_step_inverse = val;
			lpsp_pkg::REG_AZIMUTH_STEP:    proj_cfg.azimuth_step_inverse = val;
			lpsp_pkg::REG_ROW_COUNT:       proj_cfg.row_count = val[7:0];
			lpsp_pkg::REG_COLUMN_COUNT:    proj_cfg.column_count = val[11:0];
			lpsp_pkg::REG_VALUE_SCALE:     proj_cfg.value_scale = val[23:0];
			lpsp_pkg::REG_HEIGHT_OFFSET:   proj_cfg.height_offset = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// valid stays up between back-to-back items; it drops only for a gap
	task automatic send_point(input lpsp_pkg::in_item_t p, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		board.note_point(p);
		@(negedge clk);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (board.pending_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic lpsp_pkg::in_item_t random_point();
		lpsp_pkg::in_item_t p;
		int mode;
		mode = $urandom_range(0, 5);
		p.point_label = 16'($urandom);
		case (mode)
			0: begin
				p.x_position = $urandom;
				p.y_position = $urandom;
				p.z_position = $urandom;
			end
			1: begin
				// metres scale, like a real scan
				p.x_position = $signed($urandom_range(0, 200 << 16)) - (100 << 16);
				p.y_position = $signed($urandom_range(0, 200 << 16)) - (100 << 16);
				p.z_position = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
			end
			2: begin
				p.x_position = $signed($urandom_range(0, 8)) - 4;
				p.y_position = $signed($urandom_range(0, 8)) - 4;
				p.z_position = $signed($urandom_range(0, 8)) - 4;
			end
			default: begin
				p.x_position = $signed($urandom) >>> $urandom_range(0, 31);
				p.y_position = $signed($urandom) >>> $urandom_range(0, 31);
				p.z_position = $signed($urandom) >>> $urandom_range(0, 31);
			end
		endcase
		return p;
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) send_point(random_point(), 1'b0);
	endtask

	task automatic set_config(input logic [30:0] se, input logic [31:0] es,
			input logic [31:0] as, input logic [7:0] rc, input logic [11:0] cc,
			input logic [23:0] vs, input logic [31:0] ho);
		write_reg(lpsp_pkg::REG_START_ELEVATION, {1'b0, se});
		write_reg(lpsp_pkg::REG_ELEVATION_STEP, es);
		write_reg(lpsp_pkg::REG_AZIMUTH_STEP, as);
		write_reg(lpsp_pkg::REG_ROW_COUNT, {24'd0, rc});
		write_reg(lpsp_pkg::REG_COLUMN_COUNT, {20'd0, cc});
		write_reg(lpsp_pkg::REG_VALUE_SCALE, {8'd0, vs});
		write_reg(lpsp_pkg::REG_HEIGHT_OFFSET, ho);
	endtask

	// receiver with random stalls and one long hold-off
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_stall) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				long_stall = 1'b0;
			end
			stall = $urandom_range(0, 16);
			if ($urandom_range(0, 2) == 0) stall = 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
				@(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_pixel(out_data);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		lpsp_pkg::in_item_t p;
		proj_cfg = '{lpsp_pkg::RST_START_ELEVATION, lpsp_pkg::RST_ELEVATION_STEP,
			lpsp_pkg::RST_AZIMUTH_STEP, lpsp_pkg::RST_ROW_COUNT, lpsp_pkg::RST_COLUMN_COUNT,
			lpsp_pkg::RST_VALUE_SCALE, lpsp_pkg::RST_HEIGHT_OFFSET};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: field extremes, zero range, axes, every quadrant
		p.point_label = 16'hFFFF;
		p.x_position = 0; p.y_position = 0; p.z_position = 0;
		send_point(p, 1);
		p.point_label = 16'h0000;
		p.x_position = 32'sh7FFFFFFF; p.y_position = 32'sh7FFFFFFF;
		p.z_position = 32'sh7FFFFFFF;
		send_point(p, 1);
		p.x_position = 32'sh80000000; p.y_position = 32'sh80000000;
		p.z_position = 32'sh80000000;
		send_point(p, 1);
		p.x_position = 0; p.y_position = 0; p.z_position = 1 << 16;
		send_point(p, 1);
		p.z_position = -(1 << 16);
		send_point(p, 1);
		p.z_position = -(10 << 16);
		send_point(p, 1);
		for (int i = 0; i < 8; i++) begin
			p.point_label = 16'h5A5A ^ i;
			p.x_position = (i[0] ? -1 : 1) * (5 << 16) * (i[2] ? 0 : 1);
			p.y_position = (i[1] ? -1 : 1) * (3 << 16);
			p.z_position = (i[2] ? -1 : 1) * (1 << 15);
			send_point(p, 1);
		end
		for (int i = 0; i < 6; i++) send_point(random_point(), 1'b0);
		drain_pipe();

		run_random(120);
		drain_pipe();

		// extremes of every register
		set_config(31'(lpsp_pkg::HALF_PI_Q30), 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd2, 12'd2,
			24'hFFFFFF, 32'h80000000);
		run_random(80);
		drain_pipe();
		set_config(31'd0, 32'd0, 32'd0, 8'd255, 12'd4095, 24'd0, 32'h7FFFFFFF);
		run_random(60);
		drain_pipe();
		set_config(31'd421657428, 32'd5000000, 32'd10000000, 8'd64, 12'd1024,
			24'd256, 32'd0);
		run_random(80);
		drain_pipe();
		set_config(31'd300000000, 32'd10597769, 32'd21350645, 8'd200, 12'd3000,
			24'd256000, 32'd655360);

		// fill the pipe while the receiver holds off
		long_stall = 1'b1;
		for (int i = 0; i < 120; i++) send_point(random_point(), 1'b1);
		run_random(100);

		drain_pipe();
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (error_count == 0 && board.pending_pixels.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
